// ===== rtl/core/rrop_pkg.sv =====
// shared types, constants and helpers for the rounded rectangle outline generator
`default_nettype none

package rrop_pkg;

    // field widths
    localparam int COORD_W = 16;             // width_x, height_y, vert_x, vert_y
    localparam int R_W     = 15;             // corner radius and arc offsets
    localparam int N_W     = 5;              // points_per_corner register
    localparam int CSU_W   = 31;             // shared compare-subtract unit
    localparam int R2_W    = 2 * R_W;        // radius squared
    localparam int SUM_W   = COORD_W + 2;    // signed vertex sum before clamping
    localparam int DIV_CNT_W = $clog2(R_W);  // restoring divide step count

    // default arc depth
    localparam int MAX_CORNER_POINTS_DEF = 16;

    // config register reset values
    localparam logic [COORD_W-1:0] WIDTH_RST  = 16'd1600;
    localparam logic [COORD_W-1:0] HEIGHT_RST = 16'd800;
    localparam logic [R_W-1:0]     RADIUS_RST = 15'd160;
    localparam logic [N_W-1:0]     POINTS_RST = 5'd8;

    // config register indexes
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_POINTS = 2'd3
    } t_reg_idx;

    // corner order along the outline
    typedef enum logic [1:0] {
        CORNER_TR = 2'd0,
        CORNER_BR = 2'd1,
        CORNER_BL = 2'd2,
        CORNER_TL = 2'd3
    } t_corner;

    // vertex request from the sequencer to the output stage
    typedef struct packed {
        logic               valid;
        logic [R_W-1:0]     s;      // linear offset along the arc
        logic [R_W-1:0]     q;      // square root offset
        t_corner            corner;
        logic               last;
    } t_vtx;

    // clamp a signed sum to 0..65535
    function automatic logic [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic [COORD_W-1:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (|v[SUM_W-2:COORD_W]) begin
            res = '1;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rrop_csu.sv =====
// shared compare-subtract unit used for the divide and square root steps
`default_nettype none

module rrop_csu
    import rrop_pkg::*;
(
    input  wire logic [CSU_W-1:0] i_a,
    input  wire logic [CSU_W-1:0] i_b,
    output logic                  o_ge,
    output logic [CSU_W-1:0]      o_diff
);

    logic [CSU_W:0] w_sub;

    // borrow out of the extended subtract gives the compare
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[CSU_W];
    assign o_diff = w_sub[CSU_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/rrop_seq.sv =====
// sequencer: arc offset table fill (divide, accumulate, square root) and vertex walk
`default_nettype none

module rrop_seq
    import rrop_pkg::*;
#(
    parameter int MAX_CORNER_POINTS = MAX_CORNER_POINTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_idle,
    input  wire logic [R_W-1:0]   i_cfg_r,
    input  wire logic [N_W-1:0]   i_cfg_n,
    output logic [CSU_W-1:0]      o_csu_a,
    output logic [CSU_W-1:0]      o_csu_b,
    input  wire logic             i_csu_ge,
    input  wire logic [CSU_W-1:0] i_csu_diff,
    output t_vtx                  o_vtx,
    input  wire logic             i_take
);

    localparam int CNT_W = $clog2(MAX_CORNER_POINTS + 1);
    localparam int IDX_W = (MAX_CORNER_POINTS > 1) ? $clog2(MAX_CORNER_POINTS) : 1;
    localparam logic [CSU_W-1:0] BIT_TOP = {1'b1, {(CSU_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_SQ,
        ST_LD,
        ST_ROOT,
        ST_EMIT
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_n;
    logic [R_W-1:0]       r_div;   // dividend, then quotient r / n
    logic [CNT_W-1:0]     r_rem;   // remainder r % n
    logic [CNT_W-1:0]     r_ra;    // running remainder of i*r / n
    logic [R_W-1:0]       r_s;
    logic [R2_W-1:0]      r_r2;
    logic [R2_W-1:0]      r_s2;
    logic [CSU_W-1:0]     r_v;
    logic [CSU_W-1:0]     r_res;
    logic [CSU_W-1:0]     r_bit;
    logic [IDX_W-1:0]     r_i;
    logic [IDX_W-1:0]     r_j;
    t_corner              r_c;

    logic [R_W-1:0] r_tab_s [MAX_CORNER_POINTS];
    logic [R_W-1:0] r_tab_q [MAX_CORNER_POINTS];

    logic [N_W-1:0]   w_n_eff;
    logic [IDX_W-1:0] w_last_idx;
    logic [CSU_W-1:0] w_acc_sum;
    logic [CSU_W-1:0] n_res;
    logic             w_root_done;

    always_comb begin
        priority if (i_cfg_n == '0) begin
            w_n_eff = N_W'(1);
        end else if (i_cfg_n > N_W'(MAX_CORNER_POINTS)) begin
            w_n_eff = N_W'(MAX_CORNER_POINTS);
        end else begin
            w_n_eff = i_cfg_n;
        end
    end

    assign w_last_idx  = IDX_W'(r_n - CNT_W'(1));
    assign w_acc_sum   = CSU_W'(r_ra) + CSU_W'(r_rem);
    assign w_root_done = r_bit[0];
    assign n_res       = i_csu_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // operand select for the shared unit
    always_comb begin
        unique case (r_state)
            ST_DIV: begin
                o_csu_a = CSU_W'({r_rem, r_div[R_W-1]});
                o_csu_b = CSU_W'(r_n);
            end
            ST_ACC: begin
                o_csu_a = w_acc_sum;
                o_csu_b = CSU_W'(r_n);
            end
            ST_ROOT: begin
                o_csu_a = r_v;
                o_csu_b = r_res + r_bit;
            end
            default: begin
                o_csu_a = '0;
                o_csu_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_c     <= CORNER_TR;
            r_n     <= CNT_W'(1);
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_DIV;
                        r_n     <= CNT_W'(w_n_eff);
                        r_div   <= i_cfg_r;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_r2    <= R2_W'(i_cfg_r * i_cfg_r);
                    end
                end
                ST_DIV: begin
                    r_rem <= i_csu_ge ? CNT_W'(i_csu_diff) : CNT_W'(o_csu_a);
                    r_div <= {r_div[R_W-2:0], i_csu_ge};
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(R_W - 1)) begin
                        r_state <= ST_ACC;
                        r_s     <= '0;
                        r_ra    <= '0;
                        r_i     <= '0;
                    end
                end
                ST_ACC: begin
                    // s(i) = s(i-1) + r/n, carry from the remainder
                    r_s     <= r_s + r_div + R_W'(i_csu_ge);
                    r_ra    <= i_csu_ge ? CNT_W'(i_csu_diff) : CNT_W'(w_acc_sum);
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_s2    <= R2_W'(r_s * r_s);
                    r_state <= ST_LD;
                end
                ST_LD: begin
                    r_v     <= CSU_W'(r_r2 - r_s2);
                    r_res   <= '0;
                    r_bit   <= BIT_TOP;
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (i_csu_ge) begin
                        r_v <= i_csu_diff;
                    end
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (w_root_done) begin
                        if (r_i == w_last_idx) begin
                            r_state <= ST_EMIT;
                            r_j     <= '0;
                            r_c     <= CORNER_TR;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= ST_ACC;
                        end
                    end
                end
                ST_EMIT: begin
                    if (i_take) begin
                        if (r_j == w_last_idx) begin
                            r_j <= '0;
                            r_c <= t_corner'(r_c + 2'd1);
                            if (r_c == CORNER_TL) begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_j <= r_j + IDX_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // arc offset table
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ROOT && w_root_done) begin
            r_tab_s[r_i] <= r_s;
            r_tab_q[r_i] <= R_W'(n_res);
        end
    end

    always_comb begin
        o_vtx.valid  = (r_state == ST_EMIT);
        o_vtx.s      = r_tab_s[r_j];
        o_vtx.q      = r_tab_q[r_j];
        o_vtx.corner = r_c;
        o_vtx.last   = (r_c == CORNER_TL) && (r_j == w_last_idx);
    end

    assign o_idle = (r_state == ST_IDLE);

    a_root_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> (CNT_W'(r_i) < r_n))
        else $error("table index beyond point count");

    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> $onehot(r_bit))
        else $error("root step bit not one-hot");

    a_s_le_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> (r_s <= i_cfg_r))
        else $error("arc offset exceeds radius");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && i_take && o_vtx.last) |=> (r_state == ST_IDLE))
        else $error("sequencer busy after final vertex");

endmodule

`default_nettype wire

// ===== rtl/core/rrop_vtx.sv =====
// output stage: vertex placement per corner, clamping and the output register
`default_nettype none

module rrop_vtx
    import rrop_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_vtx               i_vtx,
    output logic                    o_take,
    input  wire logic [COORD_W-1:0] i_w,
    input  wire logic [COORD_W-1:0] i_h,
    input  wire logic [R_W-1:0]     i_r,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [31:0]             m_axis_tdata,  // [15:0] vert_x, [31:16] vert_y
    output logic [1:0]              m_axis_tuser,  // [1:0] corner_id
    output logic                    m_axis_tlast   // last_vertex
);

    logic               r_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    t_corner            r_corner;
    logic               r_last;

    logic signed [SUM_W-1:0] w_w, w_h, w_r, w_s, w_q;
    logic signed [SUM_W-1:0] w_x, w_y;

    assign w_w = SUM_W'(i_w);
    assign w_h = SUM_W'(i_h);
    assign w_r = SUM_W'(i_r);
    assign w_s = SUM_W'(i_vtx.s);
    assign w_q = SUM_W'(i_vtx.q);

    always_comb begin
        unique case (i_vtx.corner)
            CORNER_TR: begin
                w_x = w_w - w_r + w_s;
                w_y = w_r - w_q;
            end
            CORNER_BR: begin
                w_x = w_w - w_r + w_q;
                w_y = w_h - w_r + w_s;
            end
            CORNER_BL: begin
                w_x = w_r - w_s;
                w_y = w_h - w_r + w_q;
            end
            CORNER_TL: begin
                w_x = w_r - w_q;
                w_y = w_r - w_s;
            end
            default: begin
                w_x = '0;
                w_y = '0;
            end
        endcase
    end

    assign o_take = i_vtx.valid && (!r_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_x      <= sat16(w_x);
            r_y      <= sat16(w_y);
            r_corner <= i_vtx.corner;
            r_last   <= i_vtx.last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {r_y, r_x};
    assign m_axis_tuser  = r_corner;
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// ===== rtl/core/rounded_rect_outline_points_top.sv =====
// top level of the rounded rectangle outline generator
// a request is taken only while the sequencer is idle, so one outline never overlaps the next
// work per request: 15 divide steps on the compare-subtract unit, then per arc point an accumulate,
//   a square, a load and the root steps, then 4*N words
// reset: synchronous active low; config registers return to 1600, 800, 160, 8 and no word is held
`default_nettype none

module rounded_rect_outline_points_top
    import rrop_pkg::*;
#(
    parameter int MAX_CORNER_POINTS = MAX_CORNER_POINTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [0] request, [7:1] zero

    // vertex stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [15:0] vert_x, [31:16] vert_y
    output logic [1:0]        m_axis_tuser,   // [1:0] corner_id
    output logic              m_axis_tlast,   // last_vertex

    // config write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);

    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic [R_W-1:0]     r_radius;
    logic [N_W-1:0]     r_points;

    logic             w_idle;
    logic             w_start;
    logic [CSU_W-1:0] w_csu_a;
    logic [CSU_W-1:0] w_csu_b;
    logic             w_csu_ge;
    logic [CSU_W-1:0] w_csu_diff;
    t_vtx             w_vtx;
    logic             w_take;

    // config writes always taken; the bus must write only while the block is idle (not enforced)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_radius <= RADIUS_RST;
            r_points <= POINTS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                REG_RADIUS: r_radius <= i_cfg_data[R_W-1:0];
                REG_POINTS: r_points <= i_cfg_data[N_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    // a word is taken only when the sequencer is idle; a zero request is dropped
    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid && w_idle && s_axis_tdata[0];

    // sequencer: fills the arc offset table shared by all corners, then walks four corners
    rrop_seq #(
        .MAX_CORNER_POINTS (MAX_CORNER_POINTS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .o_idle     (w_idle),
        .i_cfg_r    (r_radius),
        .i_cfg_n    (r_points),
        .o_csu_a    (w_csu_a),
        .o_csu_b    (w_csu_b),
        .i_csu_ge   (w_csu_ge),
        .i_csu_diff (w_csu_diff),
        .o_vtx      (w_vtx),
        .i_take     (w_take)
    );

    // one compare-subtract serves the divide, the remainder carry and the root steps
    rrop_csu u_csu (
        .i_a    (w_csu_a),
        .i_b    (w_csu_b),
        .o_ge   (w_csu_ge),
        .o_diff (w_csu_diff)
    );

    // vertex placement and the output register
    rrop_vtx u_vtx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vtx         (w_vtx),
        .o_take        (w_take),
        .i_w           (r_width),
        .i_h           (r_height),
        .i_r           (r_radius),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the rounded rectangle outline generator
`timescale 1ns / 1ps

module tb_top;
    import rrop_pkg::*;

    localparam int ARC_MAX        = MAX_CORNER_POINTS_DEF;
    localparam int SETTLE_CYCLES  = 450;     // pause after the queue drains, before a register write and at the end
    localparam int LONG_HOLD      = 3000;    // one long receiver hold-off
    localparam int WATCHDOG_LIMIT = 20000;   // cycles with no word moving on any channel
    localparam int N_DIR          = 22;
    localparam int PHASES         = 8;
    localparam int PER_PHASE      = 12;      // outline requests per random phase
    localparam int MAX_REPORTS    = 20;

    typedef enum logic {
        REQ_NONE    = 1'b0,
        REQ_OUTLINE = 1'b1
    } req_code_t;

    typedef enum logic {
        ROW_CFG = 1'b0,
        ROW_REQ = 1'b1
    } row_kind_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        t_corner     corner;
        logic        last;
    } vertex_t;

    // directed row: register write or request; spelled-out outlines use one point per corner
    typedef struct packed {
        row_kind_t         kind;
        t_reg_idx          idx;
        logic [15:0]       data;     // register value, or request code in bit 0
        logic              spelled;  // expected outline given below instead of predicted
        logic [0:3][15:0]  ex;       // tr, br, bl, tl
        logic [0:3][15:0]  ey;
    } row_t;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = 8'd0;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    t_reg_idx    cfg_idx   = REG_WIDTH;
    logic [15:0] cfg_data  = 16'd0;

    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;
    wire         m_axis_tlast;
    wire         o_cfg_ready;

    // shadow copy of the config registers
    logic [15:0] cfg_w = WIDTH_RST;
    logic [15:0] cfg_h = HEIGHT_RST;
    logic [14:0] cfg_r = RADIUS_RST;
    logic [4:0]  cfg_n = POINTS_RST;

    vertex_t vertex_q[$];     // vertices still owed by the block, oldest first
    vertex_t want_v;

    int  errors        = 0;
    int  verts_seen    = 0;
    int  outlines_sent = 0;
    int  blanks_sent   = 0;
    int  reg_writes    = 0;
    int  idle_cnt      = 0;
    bit  dirty         = 1'b0;  // a request went in since the last quiet pause
    bit  rx_holding    = 1'b0;

    row_t dir_rows [N_DIR] = '{
        // an outline with the reset config, then a word that asks for nothing
        '{ROW_REQ, REG_WIDTH,  16'd1,     1'b0, 64'd0, 64'd0},
        '{ROW_REQ, REG_WIDTH,  16'd0,     1'b0, 64'd0, 64'd0},
        // zero radius on the largest rectangle: plain corners
        '{ROW_CFG, REG_POINTS, 16'd1,     1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_RADIUS, 16'd0,     1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_WIDTH,  16'hFFFF,  1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_HEIGHT, 16'hFFFF,  1'b0, 64'd0, 64'd0},
        '{ROW_REQ, REG_WIDTH,  16'd1,     1'b1,
          {16'hFFFF, 16'hFFFF, 16'd0, 16'd0}, {16'd0, 16'hFFFF, 16'hFFFF, 16'd0}},
        // point count of zero behaves as one
        '{ROW_CFG, REG_POINTS, 16'd0,     1'b0, 64'd0, 64'd0},
        '{ROW_REQ, REG_WIDTH,  16'd1,     1'b1,
          {16'hFFFF, 16'hFFFF, 16'd0, 16'd0}, {16'd0, 16'hFFFF, 16'hFFFF, 16'd0}},
        // empty rectangle, largest radius (bit 15 dropped), count 1 from masked data
        '{ROW_CFG, REG_WIDTH,  16'd0,     1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_HEIGHT, 16'd0,     1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_RADIUS, 16'hFFFF,  1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_POINTS, 16'hFFE1,  1'b0, 64'd0, 64'd0},
        '{ROW_REQ, REG_WIDTH,  16'd1,     1'b1,
          {16'd0, 16'd0, 16'd0, 16'd32767}, {16'd32767, 16'd0, 16'd0, 16'd0}},
        // count above the arc limit, radius past both sides
        '{ROW_CFG, REG_POINTS, 16'd31,    1'b0, 64'd0, 64'd0},
        '{ROW_REQ, REG_WIDTH,  16'd1,     1'b0, 64'd0, 64'd0},
        // full-size rectangle with big radius
        '{ROW_CFG, REG_WIDTH,  16'hFFFF,  1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_HEIGHT, 16'hFFFF,  1'b0, 64'd0, 64'd0},
        '{ROW_REQ, REG_WIDTH,  16'd1,     1'b0, 64'd0, 64'd0},
        // tiny radius, count just over the limit
        '{ROW_CFG, REG_POINTS, 16'd17,    1'b0, 64'd0, 64'd0},
        '{ROW_CFG, REG_RADIUS, 16'd1,     1'b0, 64'd0, 64'd0},
        '{ROW_REQ, REG_WIDTH,  16'd1,     1'b0, 64'd0, 64'd0}
    };

    rounded_rect_outline_points_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // truncated square root, one result bit per pass
    function automatic int unsigned int_sqrt(input int unsigned v);
        longint unsigned res;
        longint unsigned t;
        res = 0;
        for (int b = 15; b >= 0; b--) begin
            t = res | (longint'(1) << b);
            if (t * t <= v) begin
                res = t;
            end
        end
        return int'(res);
    endfunction

    function automatic logic [15:0] clamp_u16(input longint v);
        if (v < 0) begin
            return 16'd0;
        end
        if (v > 65535) begin
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    // queue every vertex of one outline from the shadow config
    function automatic void build_outline();
        int unsigned pts;
        int unsigned rad;
        int unsigned r2;
        int unsigned su;
        int unsigned q;
        longint      s;
        longint      qq;
        longint      r;
        longint      w;
        longint      h;
        longint      x;
        longint      y;
        vertex_t     v;
        pts = cfg_n;
        if (pts < 1) begin
            pts = 1;
        end
        if (pts > ARC_MAX) begin
            pts = ARC_MAX;
        end
        rad = cfg_r;
        r2  = rad * rad;
        r   = rad;
        w   = cfg_w;
        h   = cfg_h;
        for (int c = 0; c < 4; c++) begin
            for (int unsigned i = 1; i <= pts; i++) begin
                su = (i * rad) / pts;
                q  = int_sqrt(r2 - su * su);
                s  = su;
                qq = q;
                case (t_corner'(c)) 
                    CORNER_TR: begin x = w - r + s;  y = r - qq;     end
                    CORNER_BR: begin x = w - r + qq; y = h - r + s;  end
                    CORNER_BL: begin x = r - s;      y = h - r + qq; end
                    default:   begin x = r - qq;     y = r - s;      end
                endcase
                v.x      = clamp_u16(x);
                v.y      = clamp_u16(y);
                v.corner = t_corner'(c);
                v.last   = (c == 3) && (i == pts);
                vertex_q = {vertex_q, v};
            end
        end
    endfunction

    // always waits for a clock edge first so a following raise of valid lands on a new edge
    task automatic wait_drained();
        do @(posedge i_clk); while (vertex_q.size() != 0);
    endtask

    task automatic send_req(input req_code_t req);
        s_valid <= 1'b1;
        s_data  <= {7'd0, req};
        do @(posedge i_clk); while (!s_axis_tready);
        dirty = 1'b1;
        if (req == REQ_OUTLINE) begin
            outlines_sent++;
        end else begin
            blanks_sent++;
        end
    endtask

    // registers only change once the block has gone quiet
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] data);
        if (dirty) begin
            s_valid <= 1'b0;
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            dirty = 1'b0;
        end
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WIDTH:  cfg_w = data;
            REG_HEIGHT: cfg_h = data;
            REG_RADIUS: cfg_r = data[14:0];
            default:    cfg_n = data[4:0];
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // vertex checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            verts_seen++;
            if (vertex_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: vertex with none expected: x %0d y %0d corner %0d last %0d",
                             $time, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser,
                             m_axis_tlast);
                end
            end else begin
                want_v = vertex_q.pop_front();
                if (m_axis_tdata[15:0] !== want_v.x) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: vert_x expected %0d got %0d", $time, want_v.x,
                                 m_axis_tdata[15:0]);
                end
                if (m_axis_tdata[31:16] !== want_v.y) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: vert_y expected %0d got %0d", $time, want_v.y,
                                 m_axis_tdata[31:16]);
                end
                if (m_axis_tuser !== want_v.corner) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: corner_id expected %0d got %0d", $time, want_v.corner,
                                 m_axis_tuser);
                end
                if (m_axis_tlast !== want_v.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: last_vertex expected %0d got %0d", $time, want_v.last,
                                 m_axis_tlast);
                end
            end
        end
    end

    // receiver: random stall patterns drawn in turn, plus one long hold-off
    initial begin : rx_pattern
        int cyc;
        int mode;
        bit held;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && verts_seen >= 1000) begin
                held       = 1'b1;
                rx_holding = 1'b1;
                m_ready   <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_holding = 1'b0;
            end
            cyc++;
            if (cyc % 256 == 0) begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= (cyc % 4) != 3;
                2:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= (cyc % 16) < 3;
            endcase
        end
    end

    // watchdog on cycles where no word moves anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt == WATCHDOG_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d vertices outstanding", $time,
                     WATCHDOG_LIMIT, vertex_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int          sent;
        int          burst;
        int          gap;
        int          minside;
        int          k;
        logic [15:0] wv;
        logic [15:0] hv;
        logic [15:0] rv;
        logic [15:0] pv;
        bit          paused;
        req_code_t   rq;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                rq = req_code_t'(dir_rows[r].data[0]);
                send_req(rq);
                if (rq == REQ_OUTLINE && dir_rows[r].spelled) begin
                    for (int c = 0; c < 4; c++) begin
                        want_v.x      = dir_rows[r].ex[c];
                        want_v.y      = dir_rows[r].ey[c];
                        want_v.corner = t_corner'(c);
                        want_v.last   = (c == 3);
                        vertex_q      = {vertex_q, want_v};
                    end
                end else if (rq == REQ_OUTLINE) begin
                    build_outline();
                end
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end

        // random phases: fresh config, then bursts of requests with some blank words
        paused = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       wv = 16'd0;
                1:       wv = 16'hFFFF;
                default: wv = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       hv = 16'd0;
                1:       hv = 16'hFFFF;
                default: hv = 16'($urandom_range(0, 65535));
            endcase
            minside = (wv < hv) ? int'(wv) : int'(hv);
            case ($urandom_range(0, 9))
                6, 7:    rv = 16'($urandom_range(0, 32767));
                8:       rv = 16'h8000 | 16'($urandom_range(0, 32767));
                9:       rv = 16'd32767;
                default: rv = 16'($urandom_range(0, minside / 2));
            endcase
            if ($urandom_range(0, 9) < 7) begin
                pv = 16'($urandom_range(1, ARC_MAX));
            end else begin
                pv = 16'($urandom_range(0, 31));
            end
            // junk above the register width must be dropped
            if ($urandom_range(0, 1) == 1) begin
                pv[15:5] = 11'($urandom_range(0, 2047));
            end
            write_reg(REG_WIDTH, wv);
            write_reg(REG_HEIGHT, hv);
            write_reg(REG_RADIUS, rv);
            write_reg(REG_POINTS, pv);

            sent = 0;
            while (sent < PER_PHASE) begin
                burst = $urandom_range(1, 6);
                for (k = 0; k < burst && sent < PER_PHASE; k++) begin
                    rq = ($urandom_range(0, 6) == 0) ? REQ_NONE : REQ_OUTLINE;
                    send_req(rq);
                    if (rq == REQ_OUTLINE) begin
                        build_outline();
                        sent++;
                    end
                end
                // mid-run pause until the block has handed back everything
                if (ph == 3 && !paused && sent >= PER_PHASE / 2) begin
                    paused = 1'b1;
                    s_valid <= 1'b0;
                    wait_drained();
                end
                // keep offering words while the receiver is held off
                if (rx_holding) begin
                    gap = 0;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       gap = 0;
                        1:       gap = $urandom_range(1, 8);
                        2:       gap = $urandom_range(20, 120);
                        default: gap = $urandom_range(300, 600);
                    endcase
                end
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d outline requests and %0d blank words over %0d register writes",
                 outlines_sent, blanks_sent, reg_writes);
        $display("run: %0d vertices compared, point counts 0..31, radii up to full scale",
                 verts_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0t: %0d mismatches", $time, errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
